// File: rtl/glcd_pkg.sv
//------------------------------------------------------------------------------
// glcd_pkg
// Types and constants shared by the group lasso coordinate descent block.
//------------------------------------------------------------------------------
package glcd_pkg;

	localparam logic [1:0] CMD_LOAD_B = 2'd0;
	localparam logic [1:0] CMD_LOAD_T = 2'd1;
	localparam logic [1:0] CMD_SOLVE  = 2'd2;

	localparam logic [2:0] REG_GROUPS  = 3'd0;
	localparam logic [2:0] REG_LENGTH  = 3'd1;
	localparam logic [2:0] REG_PENALTY = 3'd2;
	localparam logic [2:0] REG_SWEEPS  = 3'd3;
	localparam logic [2:0] REG_TOL     = 3'd4;

	typedef struct packed {
		logic [1:0]         command;
		logic [2:0]         row;
		logic [2:0]         column;
		logic signed [31:0] value;
	} glcd_in_t;

	typedef struct packed {
		logic [2:0]         out_row;
		logic [2:0]         out_column;
		logic signed [31:0] solution;
		logic               converged;
		logic               last;
	} glcd_out_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT, ST_ROW, ST_MAC_RD, ST_MAC, ST_RES, ST_SQRT, ST_FDIV,
		ST_SDIV, ST_SCALE_RD, ST_SCALE, ST_SCALE_WR, ST_CHG, ST_CHECK, ST_EMIT_RD,
		ST_EMIT
	} glcd_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_INIT, OP_ROW, OP_MAC_RD, OP_MAC, OP_RES, OP_SQRT_START,
		OP_FDIV_START, OP_SDIV_START, OP_SCALE_RD, OP_SCALE, OP_SCALE_WR,
		OP_CHG, OP_EMIT_RD
	} glcd_op_t;

	typedef struct packed {
		glcd_op_t   op;
		logic [2:0] g;
		logic [2:0] j;
		logic [2:0] k;
		logic       sweep_start;
	} glcd_cmd_t;

	typedef struct packed {
		logic unit_busy;
		logic above;
		logic small_change;
	} glcd_status_t;

endpackage

// File: rtl/glcd_datapath.sv
//------------------------------------------------------------------------------
// glcd_datapath
// Matrix stores, multiplier, residual accumulator and shared iterative units.
//------------------------------------------------------------------------------
module glcd_datapath import glcd_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_en,
	input  glcd_in_t     load_item,
	input  glcd_cmd_t    cmd,
	input  logic [30:0]  penalty,
	input  logic [31:0]  tolerance,
	output glcd_status_t status,
	output logic signed [31:0] rd_value
);

	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = -32'sh7fffffff - 32'sd1;

	logic signed [31:0] b_mem [64];
	logic signed [31:0] t_mem [64];
	logic signed [31:0] z_mem [64];
	logic signed [31:0] p_mem [64];
	logic signed [31:0] r_q [8];

	logic signed [31:0] b_rd_q, t_rd_q, z_rd_q, p_rd_q;
	logic signed [31:0] b_dat, t_dat, z_dat, p_dat;
	logic [5:0] b_ad, t_ad, z_ad, z_wad, p_wad;
	logic z_we, p_we;
	logic signed [31:0] z_wd;

	logic signed [39:0] acc_q;
	logic [63:0] sq_q, chg_q, norm_q, f_q;
	logic signed [31:0] scale_q, diag_q;
	logic above_q;

	// Shared restoring divider and square root, one bit per cycle while no command is issued.
	logic [6:0] cnt_q;
	logic       sq_mode_q;
	logic [63:0] num_q, den_q, quo_q;
	logic [64:0] rem_q;
	logic [63:0] rt_q, bit_q, rv_q;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'(SMAX)) return SMAX;
		if (v < 66'(SMIN)) return SMIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [65:0] pr;
		pr = 66'(a) * 66'(b);
		return sat32(pr >>> FRAC_BITS);
	endfunction

	logic signed [31:0] prod_s1;
	logic signed [31:0] mul_a, mul_b;

	always_comb begin
		b_ad = {cmd.g, cmd.k};
		t_ad = {cmd.g, cmd.j};
		z_ad = (cmd.op == OP_MAC_RD) ? {cmd.k, cmd.j} : {cmd.g, cmd.j};
		mul_a = (cmd.op == OP_SCALE) ? scale_q : b_rd_q;
		mul_b = (cmd.op == OP_SCALE) ? r_q[cmd.j] : z_rd_q;
	end

	always_ff @(posedge clk) begin
		if (load_en && load_item.command == CMD_LOAD_B)
			b_mem[{load_item.row, load_item.column}] <= load_item.value;
		if (load_en && load_item.command == CMD_LOAD_T)
			t_mem[{load_item.row, load_item.column}] <= load_item.value;
		if (z_we) z_mem[z_wad] <= z_wd;
		if (p_we) p_mem[p_wad] <= z_wd;
		b_rd_q <= b_mem[b_ad];
		t_rd_q <= t_mem[t_ad];
		z_rd_q <= z_mem[z_ad];
		p_rd_q <= p_mem[z_ad];
	end

	assign b_dat = b_rd_q;
	assign t_dat = t_rd_q;
	assign z_dat = z_rd_q;
	assign p_dat = p_rd_q;

	always_comb begin
		z_we = 1'b0;
		p_we = 1'b0;
		z_wad = {cmd.g, cmd.j};
		p_wad = {cmd.g, cmd.j};
		z_wd = t_dat;
		unique case (cmd.op)
			OP_INIT: begin
				z_we = 1'b1;
				p_we = 1'b1;
			end
			OP_SCALE_WR: begin
				z_we = 1'b1;
				z_wd = prod_s1;
			end
			OP_CHG: begin
				p_we = 1'b1;
				z_wd = z_dat;
			end
			default: ;
		endcase
	end

	logic signed [32:0] df;
	logic [63:0] dsq;
	logic signed [31:0] rsat;
	logic [64:0] sq_sum, chg_sum;

	always_comb begin
		df = 33'(z_dat) - 33'(p_dat);
		dsq = 64'(df * df);
		rsat = sat32(66'(acc_q));
		sq_sum = 65'(sq_q) + 65'(64'(rsat * rsat));
		chg_sum = 65'(chg_q) + 65'(dsq);
	end

	logic [63:0] tol_s;
	always_comb begin
		if (2 * FRAC_BITS >= 32) tol_s = 64'(tolerance) << (2 * FRAC_BITS - 32);
		else tol_s = 64'(tolerance) >> (32 - 2 * FRAC_BITS);
	end

	logic [64:0] rem_sh;
	logic [64:0] rt_try;
	always_comb begin
		rem_sh = {rem_q[63:0], num_q[63]};
		rt_try = 65'(rt_q) + 65'(bit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (cmd.op == OP_SQRT_START || cmd.op == OP_FDIV_START ||
					cmd.op == OP_SDIV_START)
				cnt_q <= 7'd64;
			else if (cnt_q != 7'd0 && !(sq_mode_q && cnt_q > 7'd32))
				cnt_q <= cnt_q - 7'd1;
			else if (cnt_q != 7'd0)
				cnt_q <= cnt_q - 7'd2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= fxmul(mul_a, mul_b);
		unique case (cmd.op)
			OP_ROW: begin
				sq_q <= '0;
			end
			OP_INIT: begin
				chg_q <= '0;
			end
			// The read data and the product for column k are valid on this beat.
			OP_MAC: begin
				if (cmd.k == 3'd0)
					acc_q <= (cmd.k == cmd.g) ? 40'(t_dat) : 40'(t_dat) - 40'(prod_s1);
				else if (cmd.k != cmd.g)
					acc_q <= acc_q - 40'(prod_s1);
				if (cmd.k == cmd.g) diag_q <= b_dat;
			end
			OP_RES: begin
				r_q[cmd.j] <= rsat;
				sq_q <= sq_sum[64] ? '1 : sq_sum[63:0];
			end
			OP_SQRT_START: begin
				sq_mode_q <= 1'b1;
				rv_q <= sq_q;
				rt_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_FDIV_START: begin
				sq_mode_q <= 1'b0;
				above_q <= norm_q > 64'(penalty);
				num_q <= (norm_q - 64'(penalty)) << FRAC_BITS;
				den_q <= norm_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_SDIV_START: begin
				sq_mode_q <= 1'b0;
				f_q <= quo_q;
				num_q <= quo_q << FRAC_BITS;
				den_q <= diag_q[31] ? 64'(-65'(diag_q)) : 64'(diag_q);
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_SCALE_RD: begin
				if (!above_q) scale_q <= '0;
				else if (diag_q == '0) scale_q <= (f_q != '0) ? SMAX : '0;
				else scale_q <= sat32(diag_q[31] ? -66'(quo_q) : 66'(quo_q));
			end
			OP_CHG: begin
				chg_q <= chg_sum[64] ? '1 : chg_sum[63:0];
			end
			default: ;
		endcase
		if (cmd.op == OP_ROW && cmd.sweep_start) chg_q <= '0;
		if (cnt_q != 7'd0 && cmd.op == OP_NONE) begin
			if (sq_mode_q) begin
				if (bit_q != '0) begin
					if (65'(rv_q) >= rt_try) begin
						rv_q <= rv_q - rt_try[63:0];
						rt_q <= (rt_q >> 1) + bit_q;
					end else begin
						rt_q <= rt_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				norm_q <= (bit_q == '0) ? rt_q : norm_q;
			end else begin
				num_q <= num_q << 1;
				if (rem_sh >= 65'(den_q)) begin
					rem_q <= rem_sh - 65'(den_q);
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	// The root finishes when its bit walks out, and norm_q then latches the root.
	always_comb begin
		status.unit_busy = (cnt_q != 7'd0);
		status.above = above_q;
		status.small_change = chg_q < tol_s;
	end

	assign rd_value = z_dat;

endmodule

// File: rtl/glcd_ctrl.sv
//------------------------------------------------------------------------------
// glcd_ctrl
// Sequencer that walks rows, columns and sweeps and drives the datapath.
//------------------------------------------------------------------------------
module glcd_ctrl import glcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [3:0]   p_in,
	input  logic [3:0]   d_in,
	input  logic [15:0]  max_sweeps,
	input  glcd_status_t status,
	input  logic         out_free,
	output glcd_cmd_t    cmd,
	output logic         busy,
	output logic         emit,
	output logic         emit_last,
	output logic         conv
);

	glcd_state_t state_q, state_d;
	logic [2:0] g_q, g_d, j_q, j_d, k_q, k_d, pm, dm;
	logic [15:0] sw_q, sw_d;
	logic conv_q, conv_d, first_q, first_d;

	assign pm = (p_in == 4'd0) ? 3'd0 : (p_in > 4'd8 ? 3'd7 : 3'(p_in - 4'd1));
	assign dm = (d_in == 4'd0) ? 3'd0 : (d_in > 4'd8 ? 3'd7 : 3'(d_in - 4'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			g_q <= '0;
			j_q <= '0;
			k_q <= '0;
			sw_q <= '0;
			conv_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			g_q <= g_d;
			j_q <= j_d;
			k_q <= k_d;
			sw_q <= sw_d;
			conv_q <= conv_d;
			first_q <= first_d;
		end
	end

	always_comb begin
		state_d = state_q;
		g_d = g_q;
		j_d = j_q;
		k_d = k_q;
		sw_d = sw_q;
		conv_d = conv_q;
		first_d = first_q;
		cmd = '{op: OP_NONE, g: g_q, j: j_q, k: k_q, sweep_start: 1'b0};
		emit = 1'b0;
		emit_last = (g_q == pm) && (j_q == dm);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_INIT;
					g_d = '0;
					j_d = '0;
					conv_d = 1'b0;
				end
			end
			// Each entry first reads the target, then writes it to both copies.
			ST_INIT: begin
				if (!first_q) begin
					first_d = 1'b1;
				end else begin
					first_d = 1'b0;
					cmd.op = OP_INIT;
					if (j_q == dm) begin
						j_d = '0;
						if (g_q == pm) begin
							g_d = '0;
							sw_d = '0;
							state_d = (max_sweeps == '0) ? ST_EMIT_RD : ST_ROW;
						end else g_d = g_q + 3'd1;
					end else j_d = j_q + 3'd1;
				end
			end
			ST_ROW: begin
				cmd.op = OP_ROW;
				cmd.sweep_start = (g_q == 3'd0);
				j_d = '0;
				k_d = '0;
				state_d = ST_MAC_RD;
			end
			ST_MAC_RD: begin
				cmd.op = OP_MAC_RD;
				state_d = ST_MAC;
			end
			ST_MAC: begin
				if (!first_q) begin
					first_d = 1'b1;
				end else begin
					first_d = 1'b0;
					cmd.op = OP_MAC;
					if (k_q == pm) state_d = ST_RES;
					else begin
						k_d = k_q + 3'd1;
						state_d = ST_MAC_RD;
					end
				end
			end
			ST_RES: begin
				cmd.op = OP_RES;
				k_d = '0;
				if (j_q == dm) begin
					j_d = '0;
					state_d = ST_SQRT;
				end else begin
					j_d = j_q + 3'd1;
					state_d = ST_MAC_RD;
				end
			end
			ST_SQRT: begin
				if (!first_q) begin
					cmd.op = OP_SQRT_START;
					first_d = 1'b1;
				end else if (!status.unit_busy) begin
					first_d = 1'b0;
					state_d = ST_FDIV;
				end
			end
			ST_FDIV: begin
				if (!first_q) begin
					cmd.op = OP_FDIV_START;
					first_d = 1'b1;
				end else if (!status.unit_busy) begin
					first_d = 1'b0;
					state_d = ST_SDIV;
				end
			end
			ST_SDIV: begin
				if (!first_q) begin
					cmd.op = OP_SDIV_START;
					first_d = 1'b1;
				end else if (!status.unit_busy) begin
					first_d = 1'b0;
					state_d = ST_SCALE_RD;
				end
			end
			ST_SCALE_RD: begin
				cmd.op = OP_SCALE_RD;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op = OP_SCALE;
				state_d = ST_SCALE_WR;
			end
			ST_SCALE_WR: begin
				cmd.op = OP_SCALE_WR;
				if (j_q == dm) begin
					j_d = '0;
					if (g_q == pm) begin
						g_d = '0;
						state_d = ST_CHG;
					end else begin
						g_d = g_q + 3'd1;
						state_d = ST_ROW;
					end
				end else begin
					j_d = j_q + 3'd1;
					state_d = ST_SCALE;
				end
			end
			ST_CHG: begin
				if (!first_q) begin
					first_d = 1'b1;
				end else begin
					first_d = 1'b0;
					cmd.op = OP_CHG;
					if (j_q == dm) begin
						j_d = '0;
						if (g_q == pm) begin
							g_d = '0;
							state_d = ST_CHECK;
						end else g_d = g_q + 3'd1;
					end else j_d = j_q + 3'd1;
				end
			end
			ST_CHECK: begin
				sw_d = sw_q + 16'd1;
				if (status.small_change) begin
					conv_d = 1'b1;
					state_d = ST_EMIT_RD;
				end else if (sw_q + 16'd1 >= max_sweeps) state_d = ST_EMIT_RD;
				else state_d = ST_ROW;
			end
			ST_EMIT_RD: begin
				cmd.op = OP_EMIT_RD;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (emit_last) begin
						g_d = '0;
						j_d = '0;
						state_d = ST_IDLE;
					end else begin
						if (j_q == dm) begin
							j_d = '0;
							g_d = g_q + 3'd1;
						end else j_d = j_q + 3'd1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign conv = conv_q;

endmodule

// File: rtl/group_lasso_coordinate_descent.sv
//------------------------------------------------------------------------------
// group_lasso_coordinate_descent
// Fixed-point group lasso solver by cyclic block coordinate descent.
//------------------------------------------------------------------------------
// Load beats are taken one per cycle while no solve is in progress and produce
// no result. A solve beat holds stall high until every solution entry has been
// placed in the output register. Each row update runs multiply-accumulate
// through the one multiplier and the matrix memories, then uses the shared
// bit-serial square-root and divider unit; a sweep adds a change-sum pass,
// and emission reads each entry before sending it and waits out any output stall.
module group_lasso_coordinate_descent import glcd_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  glcd_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output glcd_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [3:0]  groups_q, length_q;
	logic [30:0] penalty_q;
	logic [15:0] sweeps_q;
	logic [31:0] tol_q;

	glcd_cmd_t    cmd;
	glcd_status_t status;
	logic busy, emit, emit_last, conv, in_acc;
	logic signed [31:0] rd_value;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= 4'd8;
			length_q <= 4'd8;
			penalty_q <= '0;
			sweeps_q <= 16'd100;
			tol_q <= 32'd4295;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GROUPS:  groups_q <= cfg_data[3:0];
				REG_LENGTH:  length_q <= cfg_data[3:0];
				REG_PENALTY: penalty_q <= cfg_data[30:0];
				REG_SWEEPS:  sweeps_q <= cfg_data[15:0];
				REG_TOL:     tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	glcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.start(in_acc && in_data.command == CMD_SOLVE),
		.p_in(groups_q), .d_in(length_q), .max_sweeps(sweeps_q),
		.status(status), .out_free(!out_valid || !out_stall),
		.cmd(cmd), .busy(busy), .emit(emit), .emit_last(emit_last), .conv(conv)
	);

	glcd_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .load_en(in_acc), .load_item(in_data),
		.cmd(cmd), .penalty(penalty_q), .tolerance(tol_q),
		.status(status), .rd_value(rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data.out_row <= cmd.g;
			out_data.out_column <= cmd.j;
			out_data.solution <= rd_value;
			out_data.converged <= conv;
			out_data.last <= emit_last;
		end
	end

`ifndef SYNTHESIS
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> busy) else $error("emit outside a solve");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !emit) else $error("result overwritten");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> !busy) else $error("solve did not end");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the group lasso coordinate descent solver. Coupling
// and target entries are loaded, solves are issued under several register
// settings and flow-control patterns, and every emitted solution entry is
// checked against a fixed-point descent computed inside the bench.
//------------------------------------------------------------------------------
module tb_top;
	import glcd_pkg::*;

	localparam int      FRAC      = 16;
	localparam longint  CYCLE_CAP = 40000000;
	localparam int      SETTLE    = 40;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	glcd_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	glcd_out_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	group_lasso_coordinate_descent u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Mirror of the solver state and registers.
	int              coup[8][8];
	int              targ[8][8];
	int              zsol[8][8];
	int              zprev[8][8];
	int              resid[8];
	logic [3:0]      groups_q;
	logic [3:0]      length_q;
	logic [30:0]     penalty_q;
	logic [15:0]     sweeps_q;
	logic [31:0]     tol_q;

	glcd_out_t       solution_q[$];
	int              errors;
	longint          cycles;
	int              idle_pct;
	int              stall_pct;
	int              holdoff;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic int fx_mul(int x, int y);
		longint prod;
		prod = longint'(x) * longint'(y);
		return sat32(prod >>> FRAC);
	endfunction

	function automatic longint unsigned add_sat64(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s < a) ? 64'hffff_ffff_ffff_ffff : s;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic void shrink_row(int g, int p, int d);
		longint          acc, r;
		longint unsigned sq, nrm, f, mag, q;
		int              scale, diag;
		sq = 0;
		for (int j = 0; j < d; j++) begin
			acc = targ[g][j];
			for (int k = 0; k < p; k++)
				if (k != g) acc = acc - fx_mul(coup[g][k], zsol[k][j]);
			resid[j] = sat32(acc);
			r = resid[j];
			sq = add_sat64(sq, longint'(r * r));
		end
		nrm = isqrt(sq);
		scale = 0;
		if (nrm > longint'(penalty_q)) begin
			f = ((nrm - penalty_q) << FRAC) / nrm;
			diag = coup[g][g];
			if (diag == 0) begin
				scale = (f != 0) ? 32'h7fffffff : 0;
			end else begin
				mag = (diag < 0) ? -longint'(diag) : longint'(diag);
				q = (f << FRAC) / mag;
				scale = sat32((diag < 0) ? -longint'(q) : longint'(q));
			end
		end
		for (int j = 0; j < d; j++)
			zsol[g][j] = fx_mul(scale, resid[j]);
	endfunction

	// Runs the descent and queues every solution entry it should emit.
	function automatic void predict_solve();
		int              p, d;
		logic            conv;
		longint          df;
		longint unsigned change, m;
		glcd_out_t       o;
		p = (groups_q < 1) ? 1 : ((groups_q > 8) ? 8 : groups_q);
		d = (length_q < 1) ? 1 : ((length_q > 8) ? 8 : length_q);
		conv = 1'b0;
		for (int g = 0; g < p; g++)
			for (int j = 0; j < d; j++) begin
				zsol[g][j] = targ[g][j];
				zprev[g][j] = targ[g][j];
			end
		for (int s = 0; s < sweeps_q; s++) begin
			change = 0;
			for (int g = 0; g < p; g++) shrink_row(g, p, d);
			for (int g = 0; g < p; g++)
				for (int j = 0; j < d; j++) begin
					df = longint'(zsol[g][j]) - longint'(zprev[g][j]);
					m = (df < 0) ? -df : df;
					change = add_sat64(change, m * m);
					zprev[g][j] = zsol[g][j];
				end
			if (change < longint'(tol_q)) begin
				conv = 1'b1;
				break;
			end
		end
		for (int g = 0; g < p; g++)
			for (int j = 0; j < d; j++) begin
				o.out_row = 3'(g);
				o.out_column = 3'(j);
				o.solution = zsol[g][j];
				o.converged = conv;
				o.last = (g == p - 1) && (j == d - 1);
				solution_q.push_back(o);
			end
	endfunction

	// Offers one beat, honouring the sender idle rate, and updates the mirror
	// at the edge where the beat is taken.
	task automatic send_item(logic [1:0] cmd, int r, int c, int val);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.command <= cmd;
		in_data.row <= 3'(r);
		in_data.column <= 3'(c);
		in_data.value <= val;
		do @(posedge clk); while (in_stall);
		case (cmd)
			CMD_LOAD_B: coup[r][c] = val;
			CMD_LOAD_T: targ[r][c] = val;
			CMD_SOLVE:  predict_solve();
			default: ;
		endcase
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		while (solution_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GROUPS:  groups_q = val[3:0];
			REG_LENGTH:  length_q = val[3:0];
			REG_PENALTY: penalty_q = val[30:0];
			REG_SWEEPS:  sweeps_q = val[15:0];
			REG_TOL:     tol_q = val;
			default: ;
		endcase
	endtask

	task automatic configure(int p, int d, logic [31:0] pen, int sw, logic [31:0] tol);
		go_idle();
		write_reg(REG_GROUPS, p);
		write_reg(REG_LENGTH, d);
		write_reg(REG_PENALTY, pen);
		write_reg(REG_SWEEPS, sw);
		write_reg(REG_TOL, tol);
	endtask

	function automatic int modest_value();
		return int'($urandom_range(32'h3ffff)) - 32'h20000;
	endfunction

	function automatic int any_value();
		return ($urandom_range(3) == 0) ? int'($urandom) : modest_value();
	endfunction

	// Every entry is written once so that no solve reads an undefined entry.
	task automatic test_fill();
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++) begin
				send_item(CMD_LOAD_B, r, c,
					(r == c) ? int'($urandom_range(32'h30000, 32'h10000)) : modest_value() / 8);
				send_item(CMD_LOAD_T, r, c, modest_value());
			end
	endtask

	task automatic test_directed();
		configure(3, 2, 0, 4, 4295);
		send_item(CMD_SOLVE, 0, 0, 0);
		send_item(CMD_LOAD_B, 1, 1, 0);
		send_item(CMD_UNUSED, 7, 7, -1);
		send_item(CMD_SOLVE, 7, 7, 32'h7fffffff);
		configure(3, 2, 32'h7fffffff, 3, 4295);
		send_item(CMD_SOLVE, 0, 0, 0);
		configure(3, 3, 0, 0, 4295);
		send_item(CMD_SOLVE, 0, 0, 0);
		configure(0, 0, 32'h100, 5, 0);
		send_item(CMD_SOLVE, 0, 0, 0);
		send_item(CMD_LOAD_B, 0, 0, 32'h80000000);
		send_item(CMD_LOAD_T, 7, 7, 32'h7fffffff);
		send_item(CMD_LOAD_T, 0, 0, 32'h80000000);
		send_item(CMD_LOAD_B, 7, 0, 32'h7fffffff);
		configure(15, 15, 0, 2, 0);
		send_item(CMD_SOLVE, 0, 0, 0);
		// A huge penalty zeroes every row, so the second sweep changes nothing.
		configure(8, 8, 32'h7fffffff, 65535, 1);
		send_item(CMD_SOLVE, 0, 0, 0);
		configure(2, 8, 32'h40, 6, 32'hffffffff);
		send_item(CMD_SOLVE, 0, 0, 0);
		send_item(CMD_LOAD_B, 1, 1, 32'h10000);
	endtask

	task automatic test_random(int n);
		int pick;
		configure(($urandom_range(4) == 0) ? 8 : $urandom_range(4, 1), $urandom_range(8, 1),
			($urandom_range(3) == 0) ? $urandom_range(32'h7fffffff) : $urandom_range(32'h8000),
			$urandom_range(6, 1),
			($urandom_range(3) == 0) ? $urandom : $urandom_range(32'hffff));
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 14)
				send_item(CMD_SOLVE, $urandom_range(7), $urandom_range(7), $urandom);
			else if (pick < 17)
				send_item(CMD_UNUSED, $urandom_range(7), $urandom_range(7), $urandom);
			else
				send_item((pick < 58) ? CMD_LOAD_B : CMD_LOAD_T,
					$urandom_range(7), $urandom_range(7), any_value());
		end
		// Each phase ends with a solve so that its flow-control pattern meets results.
		send_item(CMD_SOLVE, 0, 0, 0);
	endtask

	// The receiver holds off for a long stretch while loads keep arriving.
	task automatic test_backpressure();
		configure(3, 4, 32'h200, 3, 4295);
		holdoff = 3000;
		send_item(CMD_SOLVE, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send_item(CMD_LOAD_T, $urandom_range(7), $urandom_range(7), modest_value());
		send_item(CMD_SOLVE, 0, 0, 0);
	endtask

	always @(posedge clk) begin
		if (holdoff > 0) begin
			out_stall <= 1'b1;
			holdoff <= holdoff - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		glcd_out_t exp_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (solution_q.size() == 0) begin
				$error("unexpected result beat row=%0d column=%0d",
					out_data.out_row, out_data.out_column);
				errors++;
			end else begin
				exp_beat = solution_q.pop_front();
				if (out_data.out_row !== exp_beat.out_row) begin
					$error("out_row expected %0d got %0d", exp_beat.out_row, out_data.out_row);
					errors++;
				end
				if (out_data.out_column !== exp_beat.out_column) begin
					$error("out_column expected %0d got %0d",
						exp_beat.out_column, out_data.out_column);
					errors++;
				end
				if (out_data.solution !== exp_beat.solution) begin
					$error("solution expected %0d got %0d",
						exp_beat.solution, out_data.solution);
					errors++;
				end
				if (out_data.converged !== exp_beat.converged) begin
					$error("converged expected %0b got %0b",
						exp_beat.converged, out_data.converged);
					errors++;
				end
				if (out_data.last !== exp_beat.last) begin
					$error("last expected %0b got %0b", exp_beat.last, out_data.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		holdoff = 0;
		groups_q = 8;
		length_q = 8;
		penalty_q = 0;
		sweeps_q = 100;
		tol_q = 4295;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill();
		test_directed();
		test_random(8);
		idle_pct = 79;
		test_random(7);
		idle_pct = 0;
		stall_pct = 79;
		test_random(7);
		idle_pct = 14;
		stall_pct = 14;
		test_random(8);
		idle_pct = 0;
		stall_pct = 0;
		test_backpressure();

		go_idle();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
